@@ sv/vrt_pkg.sv @@
// Shared types and constants for the voxel ray traversal block.
`timescale 1ns / 1ps
package vrt_pkg;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AXIS,
      ST_DIV,
      ST_MUL,
      ST_STORE,
      ST_STEP,
      ST_CHECK,
      ST_DONE
   } state_type;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   // signed voxel position width, covers the start cell and every step in range
   localparam int POS_W      = 13;
   localparam int TIME_W     = 41;
   localparam int DELTA_W    = 32;
   localparam int FRAC_W     = 17;
   localparam int QUO_W      = 33;
   localparam int DIVISOR_W  = 18;
   localparam int DIV_CNT_W  = 6;

   localparam logic [DELTA_W-1:0] DELTA_SAT = {DELTA_W{1'b1}};
   localparam logic [TIME_W-1:0]  T_INF     = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0] STEP_NEG = -13'sd1;
   localparam logic signed [POS_W-1:0] STEP_POS = 13'sd1;

endpackage

@@ sv/vrt_req_if.sv @@
// Request channel: voxel writes and ray casts.
`timescale 1ns / 1ps
interface vrt_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [22:0] origin_x;
   logic signed [22:0] origin_y;
   logic signed [22:0] origin_z;
   logic signed [17:0] dir_x;
   logic signed [17:0] dir_y;
   logic signed [17:0] dir_z;
   logic [23:0]        search_limit;
   logic [4:0]         cell_x;
   logic [4:0]         cell_y;
   logic [4:0]         cell_z;
   logic [7:0]         cell_value;

   modport source (output valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   search_limit, cell_x, cell_y, cell_z, cell_value, input ready);
   modport sink (input valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 search_limit, cell_x, cell_y, cell_z, cell_value, output ready);
endinterface

@@ sv/vrt_rsp_if.sv @@
// Response channel: one cast result per beat.
`timescale 1ns / 1ps
interface vrt_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [7:0]         block_code;
   logic signed [9:0]  block_x;
   logic signed [9:0]  block_y;
   logic signed [9:0]  block_z;
   logic [1:0]         normal_axis;
   logic               normal_negative;
   logic [23:0]        distance;

   modport source (output valid, hit, block_code, block_x, block_y, block_z, normal_axis,
                   normal_negative, distance, input ready);
   modport sink (input valid, hit, block_code, block_x, block_y, block_z, normal_axis,
                 normal_negative, distance, output ready);
endinterface

@@ sv/voxel_ray_traversal_unit.sv @@
// Voxel grid store and 3D DDA ray caster, top level.
//
// req carries beats of two kinds. A write beat (opcode 0) stores one block code
// at cell_x/y/z in the same cycle and gives no response. A cast beat (opcode 1)
// walks the grid from the origin along the direction and gives one rsp beat.
// req.ready is high only while the block is idle; a cast holds it low until its
// result has been loaded into the rsp register.
// Cast steps: per axis with a nonzero direction component, a setup state,
// the shared restoring divider (33 quotient bits, then the done flag), then a
// multiply and a store; a zero component is settled in its setup state. Then
// a step and a check state per voxel checked (one grid RAM read each), a last
// step state to end a miss at the search limit, and a load of the result into
// the rsp register.
// After reset the grid RAM is swept to air, one entry per cycle, over all
// 2^(3*GRID_BITS) entries (32768 at the default), with req.ready low.
// A stalled rsp beat holds; a new request is taken meanwhile, and the next cast
// waits for the pending beat before it loads its own result.
`timescale 1ns / 1ps
module voxel_ray_traversal_unit #(
   parameter int GRID_BITS = 5,
   parameter int CODE_BITS = 8
) (
   input  logic   clock,
   input  logic   reset,
   vrt_req_if.sink   req,
   vrt_rsp_if.source rsp
);
   localparam int ADDR_W = 3 * GRID_BITS;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int POS_W  = vrt_pkg::POS_W;
   localparam int TW     = vrt_pkg::TIME_W;
   localparam int DW     = vrt_pkg::DELTA_W;
   localparam int FW     = vrt_pkg::FRAC_W;

   vrt_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0]        clr_ff, clr_in;
   logic [1:0]               axis_ff, axis_in;
   logic signed [22:0]       org_ff [3];
   logic signed [22:0]       org_in [3];
   logic signed [17:0]       dir_ff [3];
   logic signed [17:0]       dir_in [3];
   logic [23:0]              maxd_ff, maxd_in;
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [POS_W-1:0]  pos_in [3];
   logic [DW-1:0]            delta_ff [3];
   logic [DW-1:0]            delta_in [3];
   logic [TW-1:0]            tmax_ff [3];
   logic [TW-1:0]            tmax_in [3];
   logic [TW-1:0]            trav_ff, trav_in;
   logic [1:0]               last_ff, last_in;
   logic [1:0]               sel_ff, sel_in;
   logic                     inr_ff, inr_in;
   logic [FW+DW-1:0]         prod_ff, prod_in;
   logic                     hit_ff, hit_in;
   logic [CODE_BITS-1:0]     code_ff, code_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [7:0]               rsp_code_ff, rsp_code_in;
   logic [9:0]               rsp_x_ff, rsp_x_in;
   logic [9:0]               rsp_y_ff, rsp_y_in;
   logic [9:0]               rsp_z_ff, rsp_z_in;
   logic [1:0]               rsp_axis_ff, rsp_axis_in;
   logic                     rsp_neg_ff, rsp_neg_in;
   logic [23:0]              rsp_dist_ff, rsp_dist_in;

   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr;
   logic [CODE_BITS-1:0]     ram_wdata;
   logic [ADDR_W-1:0]        ram_raddr;
   logic [CODE_BITS-1:0]     ram_rdata;

   logic                     div_start;
   logic                     div_done;
   logic [vrt_pkg::QUO_W-1:0] div_quo;
   logic signed [17:0]       cur_dir;
   logic signed [22:0]       cur_org;
   logic [vrt_pkg::DIVISOR_W-1:0] cur_abs;
   logic [FW-1:0]            cur_frac;
   logic                     req_accept;
   logic [CODE_BITS-1:0]     voxel_code;

   vrt_ram #(
      .WIDTH (CODE_BITS),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   vrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (cur_abs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req.ready  = (state_ff == vrt_pkg::ST_IDLE);
   assign req_accept = req.valid && req.ready;

   assign cur_dir  = dir_ff[axis_ff];
   assign cur_org  = org_ff[axis_ff];
   assign cur_abs  = cur_dir[17] ? vrt_pkg::DIVISOR_W'(-cur_dir)
                                 : vrt_pkg::DIVISOR_W'(cur_dir);
   // distance to the next boundary along the step direction
   assign cur_frac = (cur_dir > 18'sd0) ? (17'h10000 - {1'b0, cur_org[15:0]})
                                        : {1'b0, cur_org[15:0]};

   assign ram_raddr  = {pos_ff[2][GRID_BITS-1:0], pos_ff[1][GRID_BITS-1:0],
                        pos_ff[0][GRID_BITS-1:0]};
   assign voxel_code = inr_ff ? ram_rdata : '0;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      axis_in      = axis_ff;
      org_in       = org_ff;
      dir_in       = dir_ff;
      maxd_in      = maxd_ff;
      pos_in       = pos_ff;
      delta_in     = delta_ff;
      tmax_in      = tmax_ff;
      trav_in      = trav_ff;
      last_in      = last_ff;
      sel_in       = sel_ff;
      inr_in       = inr_ff;
      prod_in      = prod_ff;
      hit_in       = hit_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_dist_in  = rsp_dist_ff;
      ram_we       = 1'b0;
      ram_waddr    = {GRID_BITS'(req.cell_z), GRID_BITS'(req.cell_y), GRID_BITS'(req.cell_x)};
      ram_wdata    = CODE_BITS'(req.cell_value);
      div_start    = 1'b0;

      unique case (state_ff)
         vrt_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == {ADDR_W{1'b1}}) begin
               state_in = vrt_pkg::ST_IDLE;
            end
         end
         vrt_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req.opcode == vrt_pkg::OP_WRITE) begin
                  ram_we = 1'b1;
               end else begin
                  org_in[0] = req.origin_x;
                  org_in[1] = req.origin_y;
                  org_in[2] = req.origin_z;
                  dir_in[0] = req.dir_x;
                  dir_in[1] = req.dir_y;
                  dir_in[2] = req.dir_z;
                  pos_in[0] = POS_W'(req.origin_x >>> 16);
                  pos_in[1] = POS_W'(req.origin_y >>> 16);
                  pos_in[2] = POS_W'(req.origin_z >>> 16);
                  maxd_in   = req.search_limit;
                  trav_in   = '0;
                  last_in   = vrt_pkg::AXIS_Z;
                  axis_in   = vrt_pkg::AXIS_X;
                  state_in  = vrt_pkg::ST_AXIS;
               end
            end
         end
         vrt_pkg::ST_AXIS: begin
            if (cur_abs == '0) begin
               delta_in[axis_ff] = vrt_pkg::DELTA_SAT;
               tmax_in[axis_ff]  = vrt_pkg::T_INF;
               axis_in           = axis_ff + 1'b1;
               if (axis_ff == vrt_pkg::AXIS_Z) begin
                  state_in = vrt_pkg::ST_STEP;
               end
            end else begin
               div_start = 1'b1;
               state_in  = vrt_pkg::ST_DIV;
            end
         end
         vrt_pkg::ST_DIV: begin
            if (div_done) begin
               delta_in[axis_ff] = div_quo[vrt_pkg::QUO_W-1] ? vrt_pkg::DELTA_SAT
                                                             : div_quo[DW-1:0];
               state_in = vrt_pkg::ST_MUL;
            end
         end
         vrt_pkg::ST_MUL: begin
            prod_in  = cur_frac * delta_ff[axis_ff];
            state_in = vrt_pkg::ST_STORE;
         end
         vrt_pkg::ST_STORE: begin
            tmax_in[axis_ff] = TW'(prod_ff[FW+DW-1:16]);
            axis_in          = axis_ff + 1'b1;
            state_in         = (axis_ff == vrt_pkg::AXIS_Z) ? vrt_pkg::ST_STEP
                                                            : vrt_pkg::ST_AXIS;
         end
         vrt_pkg::ST_STEP: begin
            // read issues now; choose the next axis while the data comes back
            inr_in = (pos_ff[0][POS_W-1:GRID_BITS] == '0) &&
                     (pos_ff[1][POS_W-1:GRID_BITS] == '0) &&
                     (pos_ff[2][POS_W-1:GRID_BITS] == '0);
            priority if (tmax_ff[0] < tmax_ff[1] && tmax_ff[0] < tmax_ff[2]) begin
               sel_in = vrt_pkg::AXIS_X;
            end else if (tmax_ff[1] < tmax_ff[2]) begin
               sel_in = vrt_pkg::AXIS_Y;
            end else begin
               sel_in = vrt_pkg::AXIS_Z;
            end
            if (trav_ff < TW'(maxd_ff)) begin
               state_in = vrt_pkg::ST_CHECK;
            end else begin
               hit_in   = 1'b0;
               state_in = vrt_pkg::ST_DONE;
            end
         end
         vrt_pkg::ST_CHECK: begin
            if (voxel_code != '0) begin
               hit_in   = 1'b1;
               code_in  = voxel_code;
               state_in = vrt_pkg::ST_DONE;
            end else begin
               trav_in         = tmax_ff[sel_ff];
               tmax_in[sel_ff] = tmax_ff[sel_ff] + TW'(delta_ff[sel_ff]);
               pos_in[sel_ff]  = pos_ff[sel_ff] + ((dir_ff[sel_ff] > 18'sd0) ?
                                 vrt_pkg::STEP_POS : vrt_pkg::STEP_NEG);
               last_in         = sel_ff;
               state_in        = vrt_pkg::ST_STEP;
            end
         end
         vrt_pkg::ST_DONE: begin
            // hold until the previous beat has gone
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               if (hit_ff) begin
                  rsp_code_in = 8'(code_ff);
                  rsp_x_in    = pos_ff[0][9:0];
                  rsp_y_in    = pos_ff[1][9:0];
                  rsp_z_in    = pos_ff[2][9:0];
                  rsp_axis_in = last_ff;
                  rsp_neg_in  = (dir_ff[last_ff] > 18'sd0);
                  rsp_dist_in = trav_ff[23:0];
               end else begin
                  rsp_code_in = '0;
                  rsp_x_in    = '0;
                  rsp_y_in    = '0;
                  rsp_z_in    = '0;
                  rsp_axis_in = vrt_pkg::AXIS_X;
                  rsp_neg_in  = 1'b0;
                  rsp_dist_in = maxd_ff;
               end
               state_in = vrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff     <= axis_in;
      org_ff      <= org_in;
      dir_ff      <= dir_in;
      maxd_ff     <= maxd_in;
      pos_ff      <= pos_in;
      delta_ff    <= delta_in;
      tmax_ff     <= tmax_in;
      trav_ff     <= trav_in;
      last_ff     <= last_in;
      sel_ff      <= sel_in;
      inr_ff      <= inr_in;
      prod_ff     <= prod_in;
      hit_ff      <= hit_in;
      code_ff     <= code_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_code_ff <= rsp_code_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_axis_ff <= rsp_axis_in;
      rsp_neg_ff  <= rsp_neg_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.hit             = rsp_hit_ff;
   assign rsp.block_code      = rsp_code_ff;
   assign rsp.block_x         = rsp_x_ff;
   assign rsp.block_y         = rsp_y_ff;
   assign rsp.block_z         = rsp_z_ff;
   assign rsp.normal_axis     = rsp_axis_ff;
   assign rsp.normal_negative = rsp_neg_ff;
   assign rsp.distance        = rsp_dist_ff;

`ifndef SYNTHESIS
   a_no_req_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == vrt_pkg::ST_CLEAR) |-> !req.ready)
      else $error("request taken during grid clear");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff) == vrt_pkg::ST_DONE)
      else $error("response raised outside result load");

   a_no_write_in_walk : assert property (@(posedge clock) disable iff (reset)
      (state_ff == vrt_pkg::ST_STEP || state_ff == vrt_pkg::ST_CHECK) |-> !ram_we)
      else $error("grid written during a walk");

   a_miss_distance : assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp.valid) && !rsp.hit) |-> (rsp.distance == maxd_ff))
      else $error("miss distance differs from search limit");
`endif
endmodule

@@ sv/vrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/vrt_div.sv @@
// Restoring divider forming 2^32 / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module vrt_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [vrt_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           done,
   output logic [vrt_pkg::QUO_W-1:0]      quotient
);
   localparam logic [vrt_pkg::DIV_CNT_W-1:0] LAST = vrt_pkg::DIV_CNT_W'(vrt_pkg::QUO_W - 1);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [vrt_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [vrt_pkg::DIVISOR_W:0]         rem_ff, rem_in;
   logic [vrt_pkg::QUO_W-1:0]           quo_ff, quo_in;
   logic [vrt_pkg::DIVISOR_W-1:0]       dvs_ff, dvs_in;
   logic [vrt_pkg::DIVISOR_W:0]         trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      // dividend is a single one in its top bit
      trial   = {rem_ff[vrt_pkg::DIVISOR_W-1:0], (cnt_ff == '0)};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[vrt_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[vrt_pkg::QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ bench/tb_voxel_ray_traversal_unit.sv @@
// Self-checking testbench for the voxel ray traversal unit: grid writes and DDA ray casts.
`timescale 1ns / 1ps
module tb_voxel_ray_traversal_unit;

   localparam int  RANDOM_ITEMS = 1600;
   localparam int  CYCLE_LIMIT  = 12000000;
   localparam int  HOLD_CYCLES  = 400;
   localparam int  ONE          = 65536;

   typedef struct {
      logic               op;
      logic signed [22:0] ox, oy, oz;
      logic signed [17:0] dx, dy, dz;
      logic [23:0]        maxd;
      logic [4:0]         cx, cy, cz;
      logic [7:0]         val;
   } ray_req_type;

   typedef struct {
      logic               hit;
      logic [7:0]         code;
      logic signed [9:0]  bx, by, bz;
      logic [1:0]         axis;
      logic               neg;
      logic [23:0]        travel;
   } ray_rsp_type;

   typedef struct {
      ray_req_type item;
      bit          typed;
      ray_rsp_type result;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vrt_req_if req_ch ();
   vrt_rsp_if rsp_ch ();

   voxel_ray_traversal_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [7:0]    shadow_grid [0:32767];
   ray_rsp_type   pending_casts [$];
   plan_row_type  issued_rows [$];
   plan_row_type  directed_plan [$];
   int            beats_taken   = 0;
   int            mismatches    = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            hold_left     = 0;

   // Walk the grid the way the block should and return the cast result.
   function automatic ray_rsp_type trace_ray(input ray_req_type r);
      ray_rsp_type       o;
      longint            pos [3];
      longint            org, dir, frac;
      longint unsigned   dl [3], tm [3];
      longint unsigned   ad, trav;
      int                stp [3];
      int                last, ax;
      logic [7:0]        code;
      o = '{hit: 1'b0, code: 8'd0, bx: 10'sd0, by: 10'sd0, bz: 10'sd0,
            axis: vrt_pkg::AXIS_X, neg: 1'b0, travel: r.maxd};
      for (int a = 0; a < 3; a++) begin
         org = (a == 0) ? longint'(r.ox) : (a == 1) ? longint'(r.oy) : longint'(r.oz);
         dir = (a == 0) ? longint'(r.dx) : (a == 1) ? longint'(r.dy) : longint'(r.dz);
         pos[a] = org >>> 16;
         ad = (dir < 0) ? longint'(-dir) : longint'(dir);
         stp[a] = (dir > 0) ? 1 : -1;
         if (ad == 0) begin
            dl[a] = 64'hFFFF_FFFF;
            tm[a] = 64'd1 << 40;
         end else begin
            dl[a] = (64'd1 << 32) / ad;
            if (dl[a] > 64'hFFFF_FFFF) dl[a] = 64'hFFFF_FFFF;
            frac = (dir > 0) ? (pos[a] + 1) * ONE - org : org - pos[a] * ONE;
            tm[a] = (longint'(frac) * dl[a]) >> 16;
         end
      end
      trav = 0;
      last = -1;
      while (trav < r.maxd) begin
         code = 8'd0;
         if (pos[0] >= 0 && pos[1] >= 0 && pos[2] >= 0 && pos[0] < 32 && pos[1] < 32 &&
             pos[2] < 32)
            code = shadow_grid[pos[0] | (pos[1] << 5) | (pos[2] << 10)];
         if (code != 8'd0) begin
            ax = (last < 0) ? 2 : last;
            o.hit    = 1'b1;
            o.code   = code;
            o.bx     = pos[0][9:0];
            o.by     = pos[1][9:0];
            o.bz     = pos[2][9:0];
            o.axis   = ax[1:0];
            o.neg    = stp[ax] > 0;
            o.travel = trav[23:0];
            return o;
         end
         if (tm[0] < tm[1] && tm[0] < tm[2]) ax = 0;
         else if (tm[1] < tm[2]) ax = 1;
         else ax = 2;
         trav = tm[ax];
         tm[ax] += dl[ax];
         pos[ax] += stp[ax];
         last = ax;
      end
      return o;
   endfunction

   function automatic ray_req_type cast_item(input int ox, oy, oz, dx, dy, dz, input int md);
      ray_req_type r;
      r = '{op: vrt_pkg::OP_CAST, ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz, maxd: md,
            cx: 5'd0, cy: 5'd0, cz: 5'd0, val: 8'd0};
      return r;
   endfunction

   function automatic ray_req_type write_item(input int x, y, z, v);
      ray_req_type r;
      r = '{op: vrt_pkg::OP_WRITE, ox: 23'sd0, oy: 23'sd0, oz: 23'sd0, dx: 18'sd0,
            dy: 18'sd0, dz: 18'sd0, maxd: 24'd0, cx: x, cy: y, cz: z, val: v};
      return r;
   endfunction

   function automatic ray_rsp_type miss_result(input int md);
      ray_rsp_type o;
      o = '{hit: 1'b0, code: 8'd0, bx: 10'sd0, by: 10'sd0, bz: 10'sd0,
            axis: vrt_pkg::AXIS_X, neg: 1'b0, travel: md};
      return o;
   endfunction

   function automatic ray_rsp_type start_hit(input int code, input bit neg);
      ray_rsp_type o;
      o = '{hit: 1'b1, code: code, bx: 10'sd0, by: 10'sd0, bz: 10'sd0,
            axis: vrt_pkg::AXIS_Z, neg: neg, travel: 24'd0};
      return o;
   endfunction

   function automatic int rand_dir();
      int p;
      p = $urandom_range(0, 99);
      if (p < 15) return 0;
      if (p < 25) return ($urandom_range(0, 1) != 0) ? ONE : -ONE;
      return int'($urandom_range(0, 2 * ONE)) - ONE;
   endfunction

   function automatic int rand_origin();
      if ($urandom_range(0, 99) < 15) return int'({$urandom} << 9) >>> 9;
      return int'($urandom_range(0, 10 * ONE)) - ONE;
   endfunction

   // Most casts start near the populated corner so that hits are common.
   function automatic ray_req_type random_item();
      int lim;
      if ($urandom_range(0, 99) < 45) begin
         lim = ($urandom_range(0, 99) < 80) ? 7 : 31;
         return write_item($urandom_range(0, lim), $urandom_range(0, lim),
                           $urandom_range(0, lim),
                           ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(0, 255));
      end
      return cast_item(rand_origin(), rand_origin(), rand_origin(), rand_dir(), rand_dir(),
                       rand_dir(), ($urandom_range(0, 99) < 8) ? int'($urandom & 24'hFFFFFF)
                                                                : $urandom_range(0, 24 * ONE));
   endfunction

   task automatic send_beat(input plan_row_type row);
      int start;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.opcode       = row.item.op;
      req_ch.origin_x     = row.item.ox;
      req_ch.origin_y     = row.item.oy;
      req_ch.origin_z     = row.item.oz;
      req_ch.dir_x        = row.item.dx;
      req_ch.dir_y        = row.item.dy;
      req_ch.dir_z        = row.item.dz;
      req_ch.search_limit = row.item.maxd;
      req_ch.cell_x       = row.item.cx;
      req_ch.cell_y       = row.item.cy;
      req_ch.cell_z       = row.item.cz;
      req_ch.cell_value   = row.item.val;
      issued_rows.push_back(row);
      req_ch.valid = 1'b1;
      start = beats_taken;
      do @(negedge clock); while (beats_taken == start);
   endtask

   task automatic drain_casts();
      req_ch.valid = 1'b0;
      while (pending_casts.size() != 0) @(negedge clock);
   endtask

   // Request beats: update the shadow grid or predict the cast.
   always @(posedge clock) begin
      ray_req_type  it;
      plan_row_type row;
      if (!reset && req_ch.valid && req_ch.ready) begin
         beats_taken++;
         row = issued_rows.pop_front();
         it  = row.item;
         if (it.op == vrt_pkg::OP_WRITE)
            shadow_grid[{it.cz, it.cy, it.cx}] = it.val;
         else if (row.typed)
            pending_casts.push_back(row.result);
         else
            pending_casts.push_back(trace_ray(it));
      end
   end

   // Response beats: compare against the oldest prediction.
   always @(posedge clock) begin
      ray_rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{hit: rsp_ch.hit, code: rsp_ch.block_code, bx: rsp_ch.block_x,
                 by: rsp_ch.block_y, bz: rsp_ch.block_z, axis: rsp_ch.normal_axis,
                 neg: rsp_ch.normal_negative, travel: rsp_ch.distance};
         if (pending_casts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", got);
         end else begin
            want = pending_casts.pop_front();
            if (got.hit !== want.hit || got.code !== want.code || got.bx !== want.bx ||
                got.by !== want.by || got.bz !== want.bz || got.axis !== want.axis ||
                got.neg !== want.neg || got.travel !== want.travel) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = $urandom_range(0, 99) >= recv_idle_pct;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      plan_row_type row;
      ray_rsp_type  none;
      for (int i = 0; i < 32768; i++) shadow_grid[i] = 8'd0;
      req_ch.valid = 1'b0;
      req_ch.opcode = vrt_pkg::OP_WRITE;
      {req_ch.origin_x, req_ch.origin_y, req_ch.origin_z} = '0;
      {req_ch.dir_x, req_ch.dir_y, req_ch.dir_z, req_ch.search_limit} = '0;
      {req_ch.cell_x, req_ch.cell_y, req_ch.cell_z, req_ch.cell_value} = '0;
      none = miss_result(0);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows; typed results only where they are obvious.
      directed_plan = '{
         '{cast_item(ONE/2, ONE/2, ONE/2, ONE, 0, 0, 24'hFFFFFF), 1, miss_result(24'hFFFFFF)},
         '{cast_item(ONE/2, ONE/2, ONE/2, 0, 0, ONE, 0), 1, miss_result(0)},
         '{write_item(0, 0, 0, 5), 0, none},
         '{cast_item(ONE/2, ONE/2, ONE/2, 0, 0, 0, 100), 1, start_hit(5, 0)},
         '{cast_item(ONE/2, ONE/2, ONE/2, 0, 0, ONE, 100), 1, start_hit(5, 1)},
         '{cast_item(ONE/2, ONE/2, ONE/2, 0, 0, -ONE, 100), 1, start_hit(5, 0)},
         '{write_item(31, 31, 31, 255), 0, none},
         '{cast_item(4194303, 4194303, 4194303, -ONE, -ONE, -ONE, 40 * ONE), 0, none},
         '{cast_item(-4194304, -4194304, -4194304, ONE, ONE, ONE, 24'hFFFFFF), 0, none},
         '{write_item(3, 0, 0, 9), 0, none},
         '{cast_item(ONE/2 + ONE, ONE/2, ONE/2, ONE, 0, 0, 10 * ONE), 0, none},
         '{write_item(1, 1, 0, 7), 0, none},
         '{cast_item(ONE/2 + ONE, ONE/2 + ONE, ONE/2, 46341, 46341, 0, 8 * ONE), 0, none},
         '{cast_item(ONE, ONE, ONE/2, ONE, ONE, 0, 8 * ONE), 0, none},
         '{write_item(0, 0, 0, 0), 0, none},
         '{cast_item(ONE/2, ONE/2, ONE/2, -ONE, 0, 0, 6 * ONE), 0, none},
         '{cast_item(ONE/2, ONE/2, 2 * ONE, 0, 0, -ONE, 6 * ONE), 0, none},
         '{cast_item(ONE/2, ONE/2, ONE/2, 1, 0, 0, 6 * ONE), 0, none},
         '{write_item(31, 0, 31, 128), 0, none},
         '{cast_item(31 * ONE, ONE/2, ONE/2, 0, -1, ONE, 40 * ONE), 0, none},
         '{cast_item(-4194304, 0, 0, -ONE, -ONE, -ONE, 5 * ONE), 0, none},
         '{cast_item(5 * ONE + 100, ONE/2 + ONE, ONE/2, -65535, 3, 2, 10 * ONE), 0, none}
      };
      send_idle_pct = 28;
      recv_idle_pct = 85;
      foreach (directed_plan[i]) send_beat(directed_plan[i]);
      drain_casts();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 85 : 0;
         recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 28 : 0;
         // fill the block against a stalled response side
         if (phase == 2) hold_left = HOLD_CYCLES;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            row = '{random_item(), 0, none};
            send_beat(row);
         end
         drain_casts();
      end

      repeat (300) @(negedge clock);
      if (mismatches == 0 && pending_casts.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
